@@ rtl/lkv_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the LRU key/value cache.
// No dependencies; lkv_ctrl, the top level and the checker import this package.
package lkv_pkg;

	// Field widths of a transfer.
	localparam int KEY_W = 31;
	localparam int VAL_W = 31;
	localparam int CAP_W = 5;
	localparam int OUT_W = 32;

	// Default entry count and capacity register reset value.
	localparam int unsigned ENTRIES_DEFAULT = 16;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Value returned by a get that misses.
	localparam logic [OUT_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

	// Command codes.
	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPDATE,
		ST_FINISH
	} lkv_state_t;

endpackage

@@ rtl/lkv_ram.sv @@
`timescale 1ns / 1ps
// Entry store: one write port and one read port with registered read data.
// Depends on nothing but its parameters.
module lkv_ram #(
	parameter int unsigned WIDTH = 66,
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/lkv_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the cache: scans the entry store, decides hit, insert or
// eviction, and sweeps the recency ranks back. Uses lkv_pkg.
module lkv_ctrl
	import lkv_pkg::*;
#(
	parameter int unsigned ENTRIES = ENTRIES_DEFAULT,
	parameter int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	parameter int unsigned WW = KEY_W + VAL_W + IW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               cmd,
	input  logic [KEY_W-1:0]   key,
	input  logic [VAL_W-1:0]   value,
	input  logic [CAP_W-1:0]   capacity,
	output logic               busy,
	output logic               result_valid,
	output logic               hit,
	output logic [OUT_W-1:0]   read_value,
	output logic               mem_we,
	output logic [IW-1:0]      mem_waddr,
	output logic [WW-1:0]      mem_wdata,
	output logic [IW-1:0]      mem_raddr,
	input  logic [WW-1:0]      mem_rdata
);

	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned CMW = (CW > CAP_W) ? CW : CAP_W;

	lkv_state_t state_q, state_d;

	logic             cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    count_q;
	logic             rd_vld_s1;
	logic [IW-1:0]    rd_idx_s1;
	logic             found_q;
	logic [IW-1:0]    fslot_q;
	logic [IW-1:0]    frank_q;
	logic [VAL_W-1:0] fval_q;
	logic [IW-1:0]    oldest_q;
	logic [CW-1:0]    thresh_q;
	logic [IW-1:0]    target_q;
	logic [VAL_W-1:0] newval_q;
	logic             ins_q;
	logic             result_valid_q;
	logic             hit_q;
	logic [OUT_W-1:0] read_value_q;

	logic             scan_more;
	logic             rd_en;
	logic             pass_done;
	logic [KEY_W-1:0] rd_key;
	logic [VAL_W-1:0] rd_val;
	logic [IW-1:0]    rd_rank;
	logic [IW-1:0]    last_rank;
	logic [CAP_W-1:0] cap_nz;
	logic             has_free;

	// Unpack the entry word: key, value, rank from top to bottom.
	assign rd_key  = mem_rdata[WW-1 -: KEY_W];
	assign rd_val  = mem_rdata[IW +: VAL_W];
	assign rd_rank = mem_rdata[IW-1:0];

	// The oldest held entry carries the rank one below the count.
	assign last_rank = IW'(count_q - CW'(1));

	// A zero capacity acts as one; the count never exceeds the entry count.
	assign cap_nz   = (capacity == '0) ? CAP_W'(1) : capacity;
	assign has_free = (count_q < CW'(ENTRIES)) && (CMW'(count_q) < CMW'(cap_nz));

	// Sweep control shared by the scan and the rank write-back.
	assign scan_more = idx_q < count_q;
	assign rd_en     = ((state_q == ST_SCAN) || (state_q == ST_UPDATE)) && scan_more;
	assign pass_done = !scan_more && !rd_vld_s1;
	assign mem_raddr = idx_q[IW-1:0];

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign hit          = hit_q;
	assign read_value   = read_value_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and the store's write port.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = rd_idx_s1;
		mem_wdata = {rd_key, rd_val, IW'(rd_rank + IW'(1))};
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (pass_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if ((cmd_q == CMD_GET) && !found_q) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				// Age every entry younger than the threshold; the target is written last.
				if (rd_vld_s1 && (CW'(rd_rank) < thresh_q) && (rd_idx_s1 != target_q)) begin
					mem_we = 1'b1;
				end
				if (pass_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				mem_we    = 1'b1;
				mem_waddr = target_q;
				mem_wdata = {key_q, newval_q, IW'(0)};
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers that reset clears.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1      <= 1'b0;
			result_valid_q <= 1'b0;
			count_q        <= '0;
		end else begin
			rd_vld_s1      <= rd_en;
			result_valid_q <= (state_q == ST_DECIDE) && (cmd_q == CMD_GET);
			if ((state_q == ST_FINISH) && ins_q) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// Datapath registers of the item at work.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= mem_raddr;
		if (rd_en) begin
			idx_q <= idx_q + CW'(1);
		end
		case (state_q)
			ST_IDLE: begin
				// Capture the transfer.
				if (start) begin
					cmd_q   <= cmd;
					key_q   <= key;
					val_q   <= value;
					idx_q   <= '0;
					found_q <= 1'b0;
				end
			end
			ST_SCAN: begin
				// Compare each returned entry and note the oldest.
				if (rd_vld_s1) begin
					if (rd_key == key_q) begin
						found_q <= 1'b1;
						fslot_q <= rd_idx_s1;
						frank_q <= rd_rank;
						fval_q  <= rd_val;
					end
					if (rd_rank == last_rank) begin
						oldest_q <= rd_idx_s1;
					end
				end
			end
			ST_DECIDE: begin
				idx_q    <= '0;
				newval_q <= (cmd_q == CMD_PUT) ? val_q : fval_q;
				hit_q    <= found_q;
				read_value_q <= found_q ? {1'b0, fval_q} : MISS_VALUE;
				if (found_q) begin
					// Touch: entries younger than the hit age by one.
					thresh_q <= CW'(frank_q);
					target_q <= fslot_q;
					ins_q    <= 1'b0;
				end else if (has_free) begin
					// Insert into the next free slot: every entry ages.
					thresh_q <= count_q;
					target_q <= count_q[IW-1:0];
					ins_q    <= 1'b1;
				end else begin
					// Evict the oldest: all others age.
					thresh_q <= count_q - CW'(1);
					target_q <= oldest_q;
					ins_q    <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/lru_key_value_cache_core.sv @@
`timescale 1ns / 1ps
// Top level of the LRU key/value cache: capacity register, entry store and
// sequencer. Uses lkv_pkg, lkv_ram and lkv_ctrl.
//
// A transfer is taken when start is high and busy is low. A get that misses
// keeps busy high through the scan and the decision; a get that hits or any
// put keeps it high also through the rank write-back and the write of the
// target entry. The single read port of the entry store is swept once to find
// the key and the oldest entry, and once more to write back the ranks. Each
// sweep issues one read per entry held and ends once the last read has drained
// from the registered read port.
// A get returns one result, marked by result_valid for a single cycle right
// after the scan decision. For a miss this is the first cycle with busy low.
// For a hit it falls inside the rank write-back, while busy is still high. The
// receiver cannot stall the result, so it must take it then. A put returns
// nothing. The capacity register is written with cfg_we and cfg_wdata and
// should change only while busy is low; zero acts as one.
module lru_key_value_cache_core
	import lkv_pkg::*;
#(
	parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             cmd,
	input  logic [KEY_W-1:0] key,
	input  logic [VAL_W-1:0] value,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	output logic             result_valid,
	output logic             hit,
	output logic [OUT_W-1:0] read_value
);

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned WW = KEY_W + VAL_W + IW;

	logic [CAP_W-1:0] capacity_q;
	logic             mem_we;
	logic [IW-1:0]    mem_waddr;
	logic [WW-1:0]    mem_wdata;
	logic [IW-1:0]    mem_raddr;
	logic [WW-1:0]    mem_rdata;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// Entry store.
	lkv_ram #(
		.WIDTH (WW),
		.DEPTH (ENTRIES),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Sequencer.
	lkv_ctrl #(
		.ENTRIES (ENTRIES),
		.IW      (IW),
		.WW      (WW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cmd          (cmd),
		.key          (key),
		.value        (value),
		.capacity     (capacity_q),
		.busy         (busy),
		.result_valid (result_valid),
		.hit          (hit),
		.read_value   (read_value),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

endmodule

@@ rtl/lkv_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the LRU key/value cache, bound to the top level.
// Uses lkv_pkg and lru_key_value_cache_core.
module lkv_checker
	import lkv_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             result_valid,
	input logic             hit,
	input logic [OUT_W-1:0] read_value
);

	// A result only ends an item that was at work.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without a transfer at work");

	// A result strobe lasts one cycle.
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	// A miss returns all ones.
	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !hit) |-> (read_value == MISS_VALUE))
		else $error("miss without the miss value");

	// A hit returns a non-negative stored value.
	a_hit_value: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && hit) |-> !read_value[OUT_W-1])
		else $error("hit with a negative value");

	// An accepted transfer makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transfer accepted without going busy");

endmodule

bind lru_key_value_cache_core lkv_checker u_lkv_checker (.*);
